// File: sv/md5pm_pkg.sv
// Shared constants, types and round functions of the MD5 prefix search pipeline.
package md5pm_pkg;

   localparam int NUM_ROUNDS = 64;

   // Initial chaining values
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   // Fixed padding words of a 16-byte message
   localparam logic [31:0] MSG_PAD_WORD = 32'h00000080;
   localparam logic [31:0] MSG_LEN_BITS = 32'd128;

   localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROUND_S [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   // Working state carried from one round stage to the next
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [63:0] tail;
   } round_state_type;

   function automatic logic [31:0] bswap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   // Rotate amount of a round
   function automatic int round_shift(input int r);
      return ROUND_S[((r >> 4) << 2) | (r & 3)];
   endfunction

   // Message word used by a round
   function automatic int msg_index(input int r);
      int g;
      if (r < 16) begin
         g = r;
      end else if (r < 32) begin
         g = (5 * r + 1) & 15;
      end else if (r < 48) begin
         g = (3 * r + 5) & 15;
      end else begin
         g = (7 * r) & 15;
      end
      return g;
   endfunction

   // Word g of the padded block: prefix, tail, pad byte, bit length
   function automatic logic [31:0] msg_word(input int g, input logic [31:0] m0,
                                            input logic [31:0] m1, input logic [63:0] tail);
      logic [31:0] w;
      case (g)
         0:       w = m0;
         1:       w = m1;
         2:       w = tail[31:0];
         3:       w = tail[63:32];
         4:       w = MSG_PAD_WORD;
         14:      w = MSG_LEN_BITS;
         default: w = '0;
      endcase
      return w;
   endfunction

   // Boolean mix of a round group
   function automatic logic [31:0] round_mix(input int r, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (r < 16) begin
         f = (b & c) | (~b & d);
      end else if (r < 32) begin
         f = (d & b) | (~d & c);
      end else if (r < 48) begin
         f = b ^ c ^ d;
      end else begin
         f = c ^ (b | ~d);
      end
      return f;
   endfunction

endpackage

// File: sv/md5pm_req_if.sv
// Candidate channel: valid/ready with one 64-bit candidate tail.
interface md5pm_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] candidate_tail;

   modport source (output valid, output candidate_tail, input ready);
   modport sink   (input valid, input candidate_tail, output ready);
endinterface

// File: sv/md5pm_rsp_if.sv
// Result channel: valid/ready with match flag and the two digest halves.
interface md5pm_rsp_if;
   logic        valid;
   logic        ready;
   logic        match;
   logic [63:0] digest_high;
   logic [63:0] digest_low;

   modport source (output valid, output match, output digest_high, output digest_low,
                   input ready);
   modport sink   (input valid, input match, input digest_high, input digest_low,
                   output ready);
endinterface

// File: sv/md5pm_round.sv
// One registered MD5 round stage of the pipeline.
module md5pm_round #(
   parameter int ROUND_INDEX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [31:0]                 prefix_m0,
   input  logic [31:0]                 prefix_m1,
   input  logic                        in_valid,
   input  md5pm_pkg::round_state_type  in_state,
   output logic                        out_valid,
   output md5pm_pkg::round_state_type  out_state
);

   localparam int SHIFT = md5pm_pkg::round_shift(ROUND_INDEX);
   localparam int MSG_G = md5pm_pkg::msg_index(ROUND_INDEX);

   logic [31:0]                mix;
   logic [31:0]                sum;
   logic [31:0]                rot;
   md5pm_pkg::round_state_type state_in;
   md5pm_pkg::round_state_type state_ff;
   logic                       valid_ff;

   // Round arithmetic: a + F + K + M, rotate, add b; then shift the words along
   always_comb begin
      mix = md5pm_pkg::round_mix(ROUND_INDEX, in_state.b, in_state.c, in_state.d);
      sum = in_state.a + mix + md5pm_pkg::ROUND_K[ROUND_INDEX]
            + md5pm_pkg::msg_word(MSG_G, prefix_m0, prefix_m1, in_state.tail);
      rot = (sum << SHIFT) | (sum >> (32 - SHIFT));
      state_in.a    = in_state.d;
      state_in.b    = in_state.b + rot;
      state_in.c    = in_state.b;
      state_in.d    = in_state.c;
      state_in.tail = in_state.tail;
   end

   // Stage register, frozen while the output is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// File: sv/md5pm_finish.sv
// Final stage: chaining add, byte swap, target compare and result register.
module md5pm_finish (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [31:0]                 target_word,
   input  logic                        in_valid,
   input  md5pm_pkg::round_state_type  in_state,
   md5pm_rsp_if.source                 rsp
);

   logic [31:0] word_a;
   logic [31:0] word_b;
   logic [31:0] word_c;
   logic [31:0] word_d;
   logic        match_in;
   logic        match_ff;
   logic        valid_ff;
   logic [63:0] high_in;
   logic [63:0] high_ff;
   logic [63:0] low_in;
   logic [63:0] low_ff;

   // Add the chaining values and put the digest into big-endian byte order
   always_comb begin
      word_a   = md5pm_pkg::bswap32(in_state.a + md5pm_pkg::IV_A);
      word_b   = md5pm_pkg::bswap32(in_state.b + md5pm_pkg::IV_B);
      word_c   = md5pm_pkg::bswap32(in_state.c + md5pm_pkg::IV_C);
      word_d   = md5pm_pkg::bswap32(in_state.d + md5pm_pkg::IV_D);
      match_in = (word_a == target_word);
      high_in  = {word_a, word_b};
      low_in   = {word_c, word_d};
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         match_ff <= match_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.match       = match_ff;
   assign rsp.digest_high = high_ff;
   assign rsp.digest_low  = low_ff;

endmodule

// File: sv/md5_prefix_match.sv
// Top level of the MD5 prefix search engine: config registers and round pipeline.
//
// Each candidate tail is appended little-endian to the configured 8-byte prefix
// and hashed as one padded MD5 block. The hash is fully unrolled into 64 round
// stages plus one finishing stage, so one candidate is accepted per clock unless
// the result is stalled. The transfer edge loads the first of the 65 stage
// registers and the result comes from the last. The whole pipeline moves together:
// it advances whenever the result register is empty or being taken, so a stalled
// result holds the pipeline; req ready is low while a result waits on rsp ready.
// Empty slots travel as bubbles and cost nothing. Prefix and target are read live
// by the stages and must only be written while no candidate is in flight.
module md5_prefix_match (
   input  logic        clock,
   input  logic        reset,
   md5pm_req_if.sink   req_ch,
   md5pm_rsp_if.source rsp_ch,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [63:0] csr_write_data
);

   localparam logic REG_MESSAGE_PREFIX = 1'b0;
   localparam logic REG_TARGET_WORD    = 1'b1;
   localparam int   NR                 = md5pm_pkg::NUM_ROUNDS;

   logic [63:0]                prefix_ff;
   logic [31:0]                target_ff;
   logic [31:0]                prefix_m0;
   logic [31:0]                prefix_m1;
   logic                       advance;
   logic [NR:0]                pipe_valid;
   md5pm_pkg::round_state_type pipe_state [NR+1];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         target_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MESSAGE_PREFIX: prefix_ff <= csr_write_data;
            REG_TARGET_WORD:    target_ff <= csr_write_data[31:0];
            default:            ;
         endcase
      end
   end

   // Prefix bytes become little-endian message words 0 and 1
   assign prefix_m0 = md5pm_pkg::bswap32(prefix_ff[63:32]);
   assign prefix_m1 = md5pm_pkg::bswap32(prefix_ff[31:0]);

   // Global advance from the result register
   assign advance      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Pipeline entry
   assign pipe_valid[0]      = req_ch.valid;
   assign pipe_state[0].a    = md5pm_pkg::IV_A;
   assign pipe_state[0].b    = md5pm_pkg::IV_B;
   assign pipe_state[0].c    = md5pm_pkg::IV_C;
   assign pipe_state[0].d    = md5pm_pkg::IV_D;
   assign pipe_state[0].tail = req_ch.candidate_tail;

   // Round stages
   for (genvar r = 0; r < NR; r++) begin : g_round
      md5pm_round #(
         .ROUND_INDEX (r)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .prefix_m0 (prefix_m0),
         .prefix_m1 (prefix_m1),
         .in_valid  (pipe_valid[r]),
         .in_state  (pipe_state[r]),
         .out_valid (pipe_valid[r+1]),
         .out_state (pipe_state[r+1])
      );
   end

   md5pm_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .target_word (target_ff),
      .in_valid    (pipe_valid[NR]),
      .in_state    (pipe_state[NR]),
      .rsp         (rsp_ch)
   );

`ifndef SYNTHESIS
   // A transfer in lands in the first round stage
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> pipe_valid[1])
      else $error("accepted candidate missing from first stage");

   // A stall freezes every stage's valid bit
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pipe_valid[NR:1]))
      else $error("pipeline moved during stall");

   // A finished last round becomes a result
   assert property (@(posedge clock) disable iff (reset)
      advance && pipe_valid[NR] |=> rsp_ch.valid)
      else $error("last round lost on its way to the output");

   // Reset empties the pipeline and the result register
   assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && (pipe_valid[NR:1] == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule
